[rtl/frpm_pkg.sv]
// Shared types, widths and constants of the fisheye remap map generator.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none
package frpm_pkg;

  localparam int COEF_W   = 48;
  localparam int PX_W     = 30;
  localparam int NORM_W   = 30;
  localparam int TH_W     = 20;
  localparam int CORD_W   = 40;
  localparam int Q_W      = 32;
  localparam int CORDIC_STEPS = 16;

  typedef enum logic [2:0] {
    REG_CENTER_ROW = 3'd0,
    REG_CENTER_COL = 3'd1,
    REG_AFFINE_C   = 3'd2,
    REG_AFFINE_D   = 3'd3,
    REG_AFFINE_E   = 3'd4,
    REG_VIEW_DEPTH = 3'd5,
    REG_OUT_ROWS   = 3'd6,
    REG_OUT_COLS   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                     en;
    logic [3:0]               idx;
    logic signed [COEF_W-1:0] value;
  } coef_ld_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic               s38;
  } mul_req_t;

  typedef struct packed {
    logic                   start;
    logic signed [PX_W-1:0] num;
    logic [NORM_W-1:0]      den;
  } div_req_t;

  function automatic logic [63:0] mag64(logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [TH_W-1:0] atan_q16(logic [3:0] i);
    logic signed [TH_W-1:0] v;
    case (i)
      4'd0:    v = TH_W'(51472);
      4'd1:    v = TH_W'(30386);
      4'd2:    v = TH_W'(16055);
      4'd3:    v = TH_W'(8150);
      4'd4:    v = TH_W'(4091);
      4'd5:    v = TH_W'(2047);
      4'd6:    v = TH_W'(1024);
      4'd7:    v = TH_W'(512);
      4'd8:    v = TH_W'(256);
      4'd9:    v = TH_W'(128);
      4'd10:   v = TH_W'(64);
      4'd11:   v = TH_W'(32);
      4'd12:   v = TH_W'(16);
      4'd13:   v = TH_W'(8);
      4'd14:   v = TH_W'(4);
      4'd15:   v = TH_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/frpm_if.sv]
// Valid/ready channel interfaces for pixel/load requests and map results.
// Depends on frpm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface frpm_in_if;
  import frpm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [3:0]               coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic [11:0]              pixel_row;
  logic [11:0]              pixel_col;
  modport source (output valid, kind, coef_index, coef_value, pixel_row, pixel_col,
                  input ready);
  modport sink (input valid, kind, coef_index, coef_value, pixel_row, pixel_col,
                output ready);
endinterface

interface frpm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] src_col;
  logic signed [31:0] src_row;
  modport source (output valid, src_col, src_row, input ready);
  modport sink (input valid, src_col, src_row, output ready);
endinterface
`default_nettype wire

[rtl/fisheye_perspective_remap_map_top.sv]
// Top level of the fisheye perspective remap map generator: registers,
// sequencer, square root, CORDIC. Uses frpm_pkg, frpm_if, frpm_cell, frpm_mul, frpm_div.
//
//  channel  dir  handshake            payload
//  in_ch    in   valid/ready          kind, coef_index, coef_value, pixel_row, pixel_col
//  out_ch   out  valid/ready          src_col, src_row
//  cfg_*    in   APB write/read       8 registers at byte address 4*index
//
// A load request is accepted in S_IDLE and writes its coefficient cell directly. A pixel
// request passes through a 32-step square root, a 16-step CORDIC, the Horner chain (one
// cell per cycle, overlapped with the dividers; below 15 coefficients the 32-step dividers
// set the pace) and five multiplies (issue, partial products, capture) on the shared 64x64
// multiplier. One pixel is in flight at a time; the output register holds a result while
// out_ch stalls. Synchronous active-low reset, no clear sweep.
`timescale 1ns / 1ps
`default_nettype none
module fisheye_perspective_remap_map_top #(
  parameter int MAX_COEFS = 16,
  parameter int MAX_DIM   = 4096
) (
  input  wire         clk,
  input  wire         rst_n,
  frpm_in_if.sink     in_ch,
  frpm_out_if.source  out_ch,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [4:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import frpm_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SQ    = 12'b000000000010,
    S_ADD   = 12'b000000000100,
    S_SQRT  = 12'b000000001000,
    S_CHK   = 12'b000000010000,
    S_CORD  = 12'b000000100000,
    S_HGO   = 12'b000001000000,
    S_HWAIT = 12'b000010000000,
    S_DWAIT = 12'b000100000000,
    S_MUL   = 12'b001000000000,
    S_SUM   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r;

  logic signed [31:0] center_row_r, center_col_r, affine_c_r, affine_d_r, affine_e_r;
  logic signed [31:0] view_depth_r;
  logic [12:0]        out_rows_r, out_cols_r;

  logic cfg_wr;
  logic [12:0] dim;
  cfg_reg_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[4:2]);
  assign dim = (int'(cfg_pwdata[12:0]) > MAX_DIM) ? 13'(MAX_DIM) : cfg_pwdata[12:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_row_r <= '0;
      center_col_r <= '0;
      affine_c_r   <= 32'sd1073741824;
      affine_d_r   <= '0;
      affine_e_r   <= '0;
      view_depth_r <= -32'sd41943040;
      out_rows_r   <= 13'd480;
      out_cols_r   <= 13'd640;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CENTER_ROW: center_row_r <= cfg_pwdata;
        REG_CENTER_COL: center_col_r <= cfg_pwdata;
        REG_AFFINE_C:   affine_c_r   <= cfg_pwdata;
        REG_AFFINE_D:   affine_d_r   <= cfg_pwdata;
        REG_AFFINE_E:   affine_e_r   <= cfg_pwdata;
        REG_VIEW_DEPTH: view_depth_r <= cfg_pwdata;
        REG_OUT_ROWS:   out_rows_r   <= dim;
        REG_OUT_COLS:   out_cols_r   <= dim;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CENTER_ROW: cfg_prdata = center_row_r;
      REG_CENTER_COL: cfg_prdata = center_col_r;
      REG_AFFINE_C:   cfg_prdata = affine_c_r;
      REG_AFFINE_D:   cfg_prdata = affine_d_r;
      REG_AFFINE_E:   cfg_prdata = affine_e_r;
      REG_VIEW_DEPTH: cfg_prdata = view_depth_r;
      REG_OUT_ROWS:   cfg_prdata = {19'b0, out_rows_r};
      REG_OUT_COLS:   cfg_prdata = {19'b0, out_cols_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // request side
  logic in_acc;
  coef_ld_t ld;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign ld.en       = in_acc && !in_ch.kind;
  assign ld.idx      = in_ch.coef_index;
  assign ld.value    = in_ch.coef_value;

  logic signed [PX_W-1:0] px_r, py_r;
  logic signed [14:0]     dx, dy;
  logic [63:0]            sqx_r, sqy_r;
  logic [63:0]            v_r, r_r, bit_r, trial;
  logic [4:0]             cnt_r;
  logic                   zero_r;
  logic signed [CORD_W-1:0] cx_r, cy_r, xsh, ysh;
  logic signed [TH_W-1:0] ang_r;
  logic signed [COEF_W-1:0] rho_r;
  logic [2:0]             mcnt_r;
  logic                   issued_r;
  logic signed [63:0]     prod_r [5];
  logic signed [31:0]     res_row_r, res_col_r;
  logic                   out_valid_r;
  logic signed [31:0]     out_col_r, out_row_r;

  assign dx = $signed({2'b00, in_ch.pixel_row, 1'b0}) - $signed({2'b00, out_rows_r});
  assign dy = $signed({2'b00, in_ch.pixel_col, 1'b0}) - $signed({2'b00, out_cols_r});
  assign trial = r_r + bit_r;
  assign xsh = cx_r >>> cnt_r[3:0];
  assign ysh = cy_r >>> cnt_r[3:0];

  // Horner chain, highest slot first
  logic signed [COEF_W-1:0] rho_c [MAX_COEFS+1];
  logic                     vld_c [MAX_COEFS+1];
  assign rho_c[MAX_COEFS] = '0;
  assign vld_c[MAX_COEFS] = (state_r == S_HGO);

  for (genvar g = 0; g < MAX_COEFS; g++) begin : g_cell
    frpm_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ld      (ld),
      .theta   (ang_r),
      .rho_in  (rho_c[g+1]),
      .vld_in  (vld_c[g+1]),
      .rho_out (rho_c[g]),
      .vld_out (vld_c[g])
    );
  end

  div_req_t dreq_u, dreq_v;
  logic dbusy_u, dbusy_v;
  logic signed [Q_W-1:0] u_q, v_q;
  assign dreq_u.start = (state_r == S_CHK) && (r_r != '0);
  assign dreq_u.num   = px_r;
  assign dreq_u.den   = r_r[NORM_W-1:0];
  assign dreq_v.start = dreq_u.start;
  assign dreq_v.num   = py_r;
  assign dreq_v.den   = r_r[NORM_W-1:0];

  frpm_div u_div_u (.clk(clk), .rst_n(rst_n), .req(dreq_u), .busy(dbusy_u), .res(u_q));
  frpm_div u_div_v (.clk(clk), .rst_n(rst_n), .req(dreq_v), .busy(dbusy_v), .res(v_q));

  mul_req_t mreq;
  logic m_done;
  logic signed [63:0] m_res;
  always_comb begin
    mreq.start = (state_r == S_MUL) && !issued_r;
    case (mcnt_r)
      3'd0: begin mreq.a = 64'(u_q);     mreq.b = 64'(rho_r);      mreq.s38 = 1'b1; end
      3'd1: begin mreq.a = 64'(v_q);     mreq.b = 64'(rho_r);      mreq.s38 = 1'b1; end
      3'd2: begin mreq.a = prod_r[0];    mreq.b = 64'(affine_c_r); mreq.s38 = 1'b0; end
      3'd3: begin mreq.a = prod_r[1];    mreq.b = 64'(affine_d_r); mreq.s38 = 1'b0; end
      default: begin mreq.a = prod_r[0]; mreq.b = 64'(affine_e_r); mreq.s38 = 1'b0; end
    endcase
  end

  frpm_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .done(m_done), .res(m_res));

  function automatic logic signed [31:0] sat32(logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      issued_r    <= 1'b0;
      cnt_r       <= '0;
      mcnt_r      <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.kind) begin
            px_r    <= {dx, 15'b0};
            py_r    <= {dy, 15'b0};
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sqx_r   <= 64'(px_r * px_r);
          sqy_r   <= 64'(py_r * py_r);
          state_r <= S_ADD;
        end
        S_ADD: begin
          v_r     <= sqx_r + sqy_r;
          r_r     <= '0;
          bit_r   <= 64'd1 << 62;
          cnt_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (v_r >= trial) begin
            v_r <= v_r - trial;
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          cnt_r <= '0;
          ang_r <= '0;
          cx_r  <= CORD_W'(r_r[NORM_W-1:0]);
          cy_r  <= CORD_W'(view_depth_r);
          if (r_r == '0) begin
            zero_r  <= 1'b1;
            state_r <= S_SUM;
          end else begin
            zero_r  <= 1'b0;
            state_r <= S_CORD;
          end
        end
        S_CORD: begin
          if (!cy_r[CORD_W-1]) begin
            cx_r  <= cx_r + ysh;
            cy_r  <= cy_r - xsh;
            ang_r <= ang_r + atan_q16(cnt_r[3:0]);
          end else begin
            cx_r  <= cx_r - ysh;
            cy_r  <= cy_r + xsh;
            ang_r <= ang_r - atan_q16(cnt_r[3:0]);
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
            state_r <= S_HGO;
          end
        end
        S_HGO: state_r <= S_HWAIT;
        S_HWAIT: begin
          if (vld_c[0]) begin
            rho_r   <= rho_c[0];
            state_r <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (!dbusy_u && !dbusy_v) begin
            mcnt_r   <= '0;
            issued_r <= 1'b0;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (m_done) begin
            prod_r[mcnt_r] <= m_res;
            issued_r       <= 1'b0;
            if (mcnt_r == 3'd4) begin
              state_r <= S_SUM;
            end else begin
              mcnt_r <= mcnt_r + 3'd1;
            end
          end
        end
        S_SUM: begin
          if (zero_r) begin
            res_row_r <= center_row_r;
            res_col_r <= center_col_r;
          end else begin
            res_row_r <= sat32(66'(prod_r[2]) + 66'(prod_r[3]) + 66'(center_row_r));
            res_col_r <= sat32(66'(prod_r[4]) + 66'(prod_r[1]) + 66'(center_col_r));
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_row_r   <= res_row_r;
            out_col_r   <= res_col_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.src_col = out_col_r;
  assign out_ch.src_row = out_row_r;
endmodule
`default_nettype wire

[rtl/frpm_cell.sv]
// One Horner cell: holds a coefficient and computes round(rho*theta / 2^16) + coef, saturated to 48 bits, per cycle.
// Depends on frpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module frpm_cell #(
  parameter int IDX = 0
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire frpm_pkg::coef_ld_t         ld,
  input  wire signed [frpm_pkg::TH_W-1:0] theta,
  input  wire signed [frpm_pkg::COEF_W-1:0] rho_in,
  input  wire                             vld_in,
  output logic signed [frpm_pkg::COEF_W-1:0] rho_out,
  output logic                            vld_out
);
  import frpm_pkg::*;

  logic signed [COEF_W-1:0] coef_r;
  logic signed [COEF_W-1:0] rho_r, rho_nxt;
  logic                     vld_r;
  logic signed [67:0]       prod;
  logic [67:0]              pm;
  logic [67:0]              rq;
  logic signed [67:0]       rs;
  logic signed [67:0]       sum;

  localparam logic signed [67:0] HI = 68'sd140737488355327;
  localparam logic signed [67:0] LO = -68'sd140737488355328;

  always_comb begin
    prod = 68'(rho_in) * 68'(theta);
    pm   = prod[67] ? 68'(-prod) : 68'(prod);
    rq   = (pm + 68'd32768) >> 16;
    rs   = prod[67] ? -$signed(rq) : $signed(rq);
    sum  = rs + 68'(coef_r);
    if (sum > HI) begin
      rho_nxt = HI[COEF_W-1:0];
    end else if (sum < LO) begin
      rho_nxt = LO[COEF_W-1:0];
    end else begin
      rho_nxt = sum[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      vld_r <= vld_in;
      if (ld.en && (int'(ld.idx) == IDX)) begin
        coef_r <= ld.value;
      end
    end
    rho_r <= rho_nxt;
  end

  assign rho_out = rho_r;
  assign vld_out = vld_r;
endmodule
`default_nettype wire

[rtl/frpm_mul.sv]
// Shared 64x64 multiply with round-half-away and 64-bit saturation.
// One 32x32 partial product per cycle. Depends on frpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module frpm_mul (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire frpm_pkg::mul_req_t req,
  output logic                done,
  output logic signed [63:0]  res
);
  import frpm_pkg::*;

  logic [63:0]        ua_r, ub_r;
  logic               neg_r, s38_r;
  logic [127:0]       acc_r;
  logic [2:0]         cnt_r;
  logic               busy_r, done_r;
  logic signed [63:0] res_r;
  logic [63:0]        p32;
  logic [127:0]       part;
  logic [127:0]       rnd;
  logic [127:0]       q;
  logic [63:0]        q64;

  always_comb begin
    p32 = 64'(ua_r[{cnt_r[0], 5'b0} +: 32]) * 64'(ub_r[{cnt_r[1], 5'b0} +: 32]);
    case (cnt_r[1:0])
      2'd0:    part = {64'b0, p32};
      2'd3:    part = {p32, 64'b0};
      default: part = {32'b0, p32, 32'b0};
    endcase
    rnd = acc_r + (s38_r ? (128'd1 << 37) : (128'd1 << 29));
    q   = s38_r ? (rnd >> 38) : (rnd >> 30);
    q64 = (q[127:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        ua_r   <= mag64(req.a);
        ub_r   <= mag64(req.b);
        neg_r  <= req.a[63] ^ req.b[63];
        s38_r  <= req.s38;
      end else if (busy_r) begin
        if (cnt_r != 3'd4) begin
          acc_r <= acc_r + part;
          cnt_r <= cnt_r + 3'd1;
        end else begin
          res_r  <= neg_r ? -$signed(q64) : $signed(q64);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
endmodule
`default_nettype wire

[rtl/frpm_div.sv]
// Restoring divider: round(num * 2^30 / den) half away from zero, one bit per cycle.
// Depends on frpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module frpm_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire frpm_pkg::div_req_t      req,
  output logic                         busy,
  output logic signed [frpm_pkg::Q_W-1:0] res
);
  import frpm_pkg::*;

  localparam int N_W = PX_W + 31;
  localparam int R_W = NORM_W + 1;

  logic              busy_r, neg_r;
  logic [5:0]        cnt_r;
  logic [R_W-1:0]    rem_r;
  logic [Q_W-1:0]    lo_r, q_r;
  logic [NORM_W-1:0] den_r;
  logic [PX_W-1:0]   nm;
  logic [N_W-1:0]    n;
  logic [R_W-1:0]    trial;
  logic              ge;

  always_comb begin
    nm    = req.num[PX_W-1] ? PX_W'(-req.num) : PX_W'(req.num);
    n     = {1'b0, nm, 30'b0} + N_W'(req.den >> 1);
    trial = {rem_r[NORM_W-1:0], lo_r[Q_W-1]};
    ge    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= req.num[PX_W-1];
        den_r  <= req.den;
        rem_r  <= R_W'(n >> Q_W);
        lo_r   <= n[Q_W-1:0];
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? (trial - {1'b0, den_r}) : trial;
        q_r   <= {q_r[Q_W-2:0], ge};
        lo_r  <= lo_r << 1;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(Q_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign busy = busy_r;
  assign res  = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule
`default_nettype wire
